@@ rtl/cshash_pkg.sv @@
// ----------------------------------------------------------------------------
// cshash_pkg
// Types, constants and the hash function shared by the hash table modules.
// ----------------------------------------------------------------------------
package cshash_pkg;

  localparam int unsigned CapacityDefault = 256;
  localparam logic [63:0] ZeroKeyHash     = 64'd1234567;
  localparam int unsigned HashRotate      = 5;

  // request codes
  typedef enum logic [1:0] {
    REQ_GET   = 2'd0,
    REQ_SET   = 2'd1,
    REQ_NEXT  = 2'd2,
    REQ_CLEAR = 2'd3
  } cs_req_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] req_key;
    logic [63:0] req_value;
  } cs_req_t;

  typedef struct packed {
    logic [63:0] result_word;
    logic        table_full;
    logic [8:0]  live_count;
  } cs_rsp_t;

  // handshake control from the wrapper to the core
  typedef struct packed {
    logic start;
    logic out_free;
  } cs_ctrl_t;

  // status from the core to the wrapper
  typedef struct packed {
    logic ready;
    logic done;
  } cs_stat_t;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_IDLE,
    ST_HOME_RD,
    ST_HOME_CHK,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_VAL_WR,
    ST_FREE_RD,
    ST_FREE_CHK,
    ST_INS_WR,
    ST_LINK_WR,
    ST_PREV_RD,
    ST_PREV_CHK,
    ST_MOVE_WR,
    ST_PLINK_WR,
    ST_HOME_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DONE
  } cs_state_e;

  // rotate right by five, key zero maps to a fixed constant
  function automatic logic [63:0] cs_hash(input logic [63:0] key);
    logic [63:0] h;
    begin
      h = (key == 64'd0) ? ZeroKeyHash : ((key >> HashRotate) | (key << (64 - HashRotate)));
      return h;
    end
  endfunction

endpackage

@@ rtl/cshash_ram.sv @@
// ----------------------------------------------------------------------------
// cshash_ram
// Single port RAM with registered read data.
// ----------------------------------------------------------------------------
module cshash_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/cshash_core.sv @@
// ----------------------------------------------------------------------------
// cshash_core
// Sequencer and slot memories: chain walks, free slot scan, node moves and
// the clearing sweep, all through one shared memory port and key compare.
// ----------------------------------------------------------------------------
module cshash_core #(
  parameter int unsigned CAPACITY = cshash_pkg::CapacityDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cshash_pkg::cs_ctrl_t ctrl_i,
  input  cshash_pkg::cs_req_t  req_i,
  output cshash_pkg::cs_stat_t stat_o,
  output cshash_pkg::cs_rsp_t  rsp_o
);
  import cshash_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned LW = IW + 1;
  localparam logic [LW-1:0] Nil     = LW'(CAPACITY);
  localparam logic [IW-1:0] LastIdx = IW'(CAPACITY - 1);

  cs_state_e    state_q, state_d;
  logic [1:0]   type_q, type_d;
  logic [63:0]  key_q, key_d, val_q, val_d;
  logic [IW-1:0] home_q, home_d;
  logic [LW-1:0] cur_q, cur_d, steps_q, steps_d, li_q, li_d;
  logic [63:0]  ki_q, ki_d, vi_q, vi_d, word_q, word_d;
  logic         same_q, same_d, full_q, full_d;
  logic [IW-1:0] fp_q, fp_d;
  logic         gone_q, gone_d, emit_q, emit_d;
  logic [8:0]   cnt_q, cnt_d;

  // memory port
  logic [IW-1:0] addr;
  logic          we_key, we_val, we_link;
  logic [63:0]   wkey, wval, rd_key, rd_val;
  logic [LW-1:0] wlink, rd_link;
  logic [IW-1:0] req_home, rd_home;
  logic          key_hit;

  cshash_ram #(.Width(64), .Depth(CAPACITY)) u_keys (
    .clk_i, .we_i(we_key), .addr_i(addr), .wdata_i(wkey), .rdata_o(rd_key)
  );
  cshash_ram #(.Width(64), .Depth(CAPACITY)) u_vals (
    .clk_i, .we_i(we_val), .addr_i(addr), .wdata_i(wval), .rdata_o(rd_val)
  );
  cshash_ram #(.Width(LW), .Depth(CAPACITY)) u_links (
    .clk_i, .we_i(we_link), .addr_i(addr), .wdata_i(wlink), .rdata_o(rd_link)
  );

  assign req_home = IW'(cs_hash(req_i.req_key));
  assign rd_home  = IW'(cs_hash(rd_key));
  // shared key comparator
  assign key_hit  = (rd_key == key_q);

  // where a failed walk leads
  function automatic cs_state_e miss_next(input logic [1:0] t, input logic vzero);
    cs_state_e s;
    begin
      s = ST_DONE;
      if ((t == REQ_SET) && !vzero) s = ST_FREE_RD;
      return s;
    end
  endfunction

  // next state and datapath
  always_comb begin
    state_d = state_q; type_d = type_q; key_d = key_q; val_d = val_q;
    home_d = home_q; cur_d = cur_q; steps_d = steps_q; li_d = li_q;
    ki_d = ki_q; vi_d = vi_q; word_d = word_q; same_d = same_q; full_d = full_q;
    fp_d = fp_q; gone_d = gone_q; emit_d = emit_q; cnt_d = cnt_q;
    addr = '0; we_key = 1'b0; we_val = 1'b0; we_link = 1'b0;
    wkey = key_q; wval = val_q; wlink = Nil;
    stat_o = '0;

    unique case (state_q)
      ST_CLR: begin
        addr = cur_q[IW-1:0];
        we_key = 1'b1; we_val = 1'b1; we_link = 1'b1;
        wkey = '0; wval = '0;
        if (cur_q[IW-1:0] == LastIdx) begin
          fp_d = LastIdx; gone_d = 1'b0; cnt_d = '0;
          word_d = '0; full_d = 1'b0;
          state_d = emit_q ? ST_DONE : ST_IDLE;
        end else begin
          cur_d = cur_q + LW'(1);
        end
      end
      ST_IDLE: begin
        stat_o.ready = 1'b1;
        if (ctrl_i.start) begin
          type_d = req_i.req_type; key_d = req_i.req_key; val_d = req_i.req_value;
          full_d = 1'b0; word_d = '0; steps_d = '0;
          home_d = req_home; cur_d = {1'b0, req_home};
          unique case (req_i.req_type)
            REQ_GET:  state_d = ST_WALK_RD;
            REQ_SET:  state_d = (req_i.req_key == '0) ? ST_DONE : ST_HOME_RD;
            REQ_NEXT: begin
              if (req_i.req_key == '0) begin
                cur_d = '0; state_d = ST_SCAN_RD;
              end else begin
                state_d = ST_HOME_RD;
              end
            end
            default: begin
              cur_d = '0; emit_d = 1'b1; state_d = ST_CLR;
            end
          endcase
        end
      end
      ST_HOME_RD: begin
        addr = home_q;
        state_d = ST_HOME_CHK;
      end
      ST_HOME_CHK: begin
        addr = home_q;
        if (rd_key == '0) begin
          state_d = ST_DONE;
          if ((type_q == REQ_SET) && (val_q != '0)) begin
            we_key = 1'b1; we_val = 1'b1; we_link = 1'b1;
            cnt_d = cnt_q + 9'd1;
          end
        end else begin
          ki_d = rd_key; vi_d = rd_val; li_d = rd_link;
          same_d = (rd_home == home_q);
          steps_d = '0;
          if ((type_q == REQ_NEXT) || (rd_home == home_q)) begin
            cur_d = {1'b0, home_q};
            state_d = ST_WALK_RD;
          end else begin
            cur_d = {1'b0, rd_home};
            state_d = (val_q == '0) ? ST_DONE : ST_FREE_RD;
          end
        end
      end
      ST_WALK_RD: begin
        addr = cur_q[IW-1:0];
        if (cur_q[IW] || (steps_q == Nil)) state_d = miss_next(type_q, val_q == '0);
        else state_d = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        addr = cur_q[IW-1:0];
        if (rd_key == '0) begin
          state_d = miss_next(type_q, val_q == '0);
        end else if (key_hit) begin
          unique case (type_q)
            REQ_GET: begin
              word_d = rd_val; state_d = ST_DONE;
            end
            REQ_NEXT: begin
              cur_d = cur_q + LW'(1); state_d = ST_SCAN_RD;
            end
            default: begin
              word_d = rd_val;
              cnt_d = cnt_q + {8'd0, val_q != '0} - {8'd0, rd_val != '0};
              state_d = ST_VAL_WR;
            end
          endcase
        end else begin
          cur_d = rd_link; steps_d = steps_q + LW'(1);
          state_d = ST_WALK_RD;
        end
      end
      ST_VAL_WR: begin
        addr = cur_q[IW-1:0];
        we_val = 1'b1;
        state_d = ST_DONE;
      end
      ST_FREE_RD: begin
        addr = fp_q;
        if (gone_q) begin
          full_d = 1'b1; state_d = ST_DONE;
        end else begin
          state_d = ST_FREE_CHK;
        end
      end
      ST_FREE_CHK: begin
        addr = fp_q;
        if (rd_key != '0) begin
          if (fp_q == '0) gone_d = 1'b1;
          else fp_d = fp_q - IW'(1);
          state_d = ST_FREE_RD;
        end else begin
          state_d = same_q ? ST_INS_WR : ST_PREV_RD;
        end
      end
      ST_INS_WR: begin
        addr = fp_q;
        we_key = 1'b1; we_val = 1'b1; we_link = 1'b1;
        wlink = li_q;
        state_d = ST_LINK_WR;
      end
      ST_LINK_WR: begin
        addr = home_q;
        we_link = 1'b1; wlink = {1'b0, fp_q};
        cnt_d = cnt_q + 9'd1;
        state_d = ST_DONE;
      end
      ST_PREV_RD: begin
        addr = cur_q[IW-1:0];
        state_d = cur_q[IW] ? ST_DONE : ST_PREV_CHK;
      end
      ST_PREV_CHK: begin
        addr = cur_q[IW-1:0];
        if (rd_link == {1'b0, home_q}) begin
          state_d = ST_MOVE_WR;
        end else if (steps_q == Nil) begin
          state_d = ST_DONE;
        end else begin
          cur_d = rd_link; steps_d = steps_q + LW'(1);
          state_d = ST_PREV_RD;
        end
      end
      ST_MOVE_WR: begin
        addr = fp_q;
        we_key = 1'b1; we_val = 1'b1; we_link = 1'b1;
        wkey = ki_q; wval = vi_q; wlink = li_q;
        state_d = ST_PLINK_WR;
      end
      ST_PLINK_WR: begin
        addr = cur_q[IW-1:0];
        we_link = 1'b1; wlink = {1'b0, fp_q};
        state_d = ST_HOME_WR;
      end
      ST_HOME_WR: begin
        addr = home_q;
        we_key = 1'b1; we_val = 1'b1; we_link = 1'b1;
        cnt_d = cnt_q + 9'd1;
        state_d = ST_DONE;
      end
      ST_SCAN_RD: begin
        addr = cur_q[IW-1:0];
        state_d = cur_q[IW] ? ST_DONE : ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        addr = cur_q[IW-1:0];
        if ((rd_key != '0) && (rd_val != '0)) begin
          word_d = rd_key; state_d = ST_DONE;
        end else begin
          cur_d = cur_q + LW'(1); state_d = ST_SCAN_RD;
        end
      end
      ST_DONE: begin
        stat_o.done = ctrl_i.out_free;
        emit_d = 1'b0;
        if (ctrl_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign rsp_o = '{result_word: word_q, table_full: full_q, live_count: cnt_q};

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      cur_q   <= '0;
      emit_q  <= 1'b0;
      fp_q    <= LastIdx;
      gone_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      emit_q  <= emit_d;
      fp_q    <= fp_d;
      gone_q  <= gone_d;
      cnt_q   <= cnt_d;
    end
  end

  // working registers of the current transaction
  always_ff @(posedge clk_i) begin
    type_q  <= type_d;
    key_q   <= key_d;
    val_q   <= val_d;
    home_q  <= home_d;
    steps_q <= steps_d;
    li_q    <= li_d;
    ki_q    <= ki_d;
    vi_q    <= vi_d;
    word_q  <= word_d;
    same_q  <= same_d;
    full_q  <= full_d;
  end

endmodule

@@ rtl/chained_scatter_hash_table.sv @@
// ----------------------------------------------------------------------------
// chained_scatter_hash_table
// Fixed capacity chained scatter hash table of 64-bit key/value pairs.
// ----------------------------------------------------------------------------
// One transaction at a time. After reset, and on a clear request, a sweep
// writes every slot. A get walks the chain nodes from the home slot; a set
// also scans occupied slots with the free pointer, may search for the
// predecessor of a displaced node and then writes the new or moved nodes and
// their links; a next key scans the slots in order. All steps go through the
// single shared port to the key, value and link memories. A finished result
// waits in an output register while the next transaction is taken.
module chained_scatter_hash_table #(
  parameter int unsigned CAPACITY = cshash_pkg::CapacityDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cshash_pkg::cs_req_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cshash_pkg::cs_rsp_t out_data_o
);
  import cshash_pkg::*;

  cs_ctrl_t ctrl;
  cs_stat_t stat;
  cs_rsp_t  rsp;
  cs_rsp_t  out_q;
  logic     out_valid_q;

  assign ctrl.start    = in_valid_i && stat.ready;
  assign ctrl.out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o    = !stat.ready;

  cshash_core #(.CAPACITY(CAPACITY)) u_core (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .req_i(in_data_i), .stat_o(stat), .rsp_o(rsp)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat.done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.done) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ verif/hash_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_table_checker
// Watches both channels of the hash table, keeps a shadow table and compares
// every result transaction against the shadow's prediction.
// ----------------------------------------------------------------------------
module hash_table_checker #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  cshash_pkg::cs_req_t in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  cshash_pkg::cs_rsp_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import cshash_pkg::*;

  localparam int unsigned Nil = CAPACITY;

  logic [63:0] shadow_keys [CAPACITY];
  logic [63:0] shadow_vals [CAPACITY];
  int unsigned shadow_links [CAPACITY];
  int unsigned free_idx;
  bit          free_exhausted;
  int unsigned live_total;

  cs_rsp_t expected_rsps[$];

  assign pending_o = expected_rsps.size();

  function automatic int unsigned home_slot(logic [63:0] k);
    logic [63:0] h;
    h = (k == 64'd0) ? 64'd1234567 : {k[4:0], k[63:5]};
    return int'(h % CAPACITY);
  endfunction

  task automatic clear_shadow();
    for (int i = 0; i < CAPACITY; i++) begin
      shadow_keys[i] = '0;
      shadow_vals[i] = '0;
      shadow_links[i] = Nil;
    end
    free_idx = CAPACITY - 1;
    free_exhausted = 0;
    live_total = 0;
  endtask

  function automatic int unsigned chain_find(int unsigned s, logic [63:0] key);
    int unsigned n;
    int unsigned steps;
    n = s;
    steps = 0;
    while (n < Nil && shadow_keys[n] != 0 && steps < CAPACITY) begin
      if (shadow_keys[n] == key) return n;
      n = shadow_links[n];
      steps++;
    end
    return Nil;
  endfunction

  function automatic bit claim_free();
    while (!free_exhausted && shadow_keys[free_idx] != 0) begin
      if (free_idx == 0) free_exhausted = 1;
      else free_idx--;
    end
    return !free_exhausted;
  endfunction

  // set transaction: returns the old value, flags a full table
  function automatic logic [63:0] store_pair(logic [63:0] key, logic [63:0] val,
                                             output bit full);
    int unsigned i, i2, e, f, prev, steps;
    logic [63:0] old;
    full = 0;
    if (key == 0) return 0;
    i = home_slot(key);
    if (shadow_keys[i] == 0) begin
      if (val == 0) return 0;
      shadow_keys[i] = key;
      shadow_vals[i] = val;
      shadow_links[i] = Nil;
      live_total++;
      return 0;
    end
    i2 = home_slot(shadow_keys[i]);
    if (i2 == i) begin
      e = chain_find(i, key);
      if (e < Nil) begin
        old = shadow_vals[e];
        if (val != 0) live_total++;
        if (old != 0) live_total--;
        shadow_vals[e] = val;
        return old;
      end
    end
    if (val == 0) return 0;
    if (!claim_free()) begin
      full = 1;
      return 0;
    end
    f = free_idx;
    if (i2 == i) begin
      shadow_keys[f] = key;
      shadow_vals[f] = val;
      shadow_links[f] = shadow_links[i];
      shadow_links[i] = f;
    end else begin
      // displace the foreign node, relinking its predecessor
      prev = i2;
      steps = 0;
      while (prev < Nil && shadow_links[prev] != i && steps < CAPACITY) begin
        prev = shadow_links[prev];
        steps++;
      end
      if (prev >= Nil || shadow_links[prev] != i) return 0;
      shadow_keys[f] = shadow_keys[i];
      shadow_vals[f] = shadow_vals[i];
      shadow_links[f] = shadow_links[i];
      shadow_links[prev] = f;
      shadow_keys[i] = key;
      shadow_vals[i] = val;
      shadow_links[i] = Nil;
    end
    live_total++;
    return 0;
  endfunction

  function automatic logic [63:0] following_key(logic [63:0] key);
    int unsigned start, i, e, steps;
    start = 0;
    if (key != 0) begin
      i = home_slot(key);
      if (shadow_keys[i] == 0) return 0;
      e = i;
      steps = 0;
      while (e < Nil && shadow_keys[e] != key && steps < CAPACITY) begin
        e = shadow_links[e];
        steps++;
      end
      if (e >= Nil || shadow_keys[e] != key) return 0;
      start = e + 1;
    end
    for (int unsigned s = start; s < CAPACITY; s++)
      if (shadow_keys[s] != 0 && shadow_vals[s] != 0) return shadow_keys[s];
    return 0;
  endfunction

  // predict one request transaction
  task automatic predict(cs_req_t rq);
    cs_rsp_t r;
    bit full;
    r = '0;
    full = 0;
    case (cs_req_e'(rq.req_type))
      REQ_GET: begin
        r.result_word = (chain_find(home_slot(rq.req_key), rq.req_key) < Nil) ?
                        shadow_vals[chain_find(home_slot(rq.req_key), rq.req_key)] : '0;
      end
      REQ_SET:  r.result_word = store_pair(rq.req_key, rq.req_value, full);
      REQ_NEXT: r.result_word = following_key(rq.req_key);
      default:  clear_shadow();
    endcase
    r.table_full = full;
    r.live_count = live_total[8:0];
    expected_rsps.push_back(r);
  endtask

  initial clear_shadow();

  // sample both channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    cs_rsp_t exp_r;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_rsps.size() == 0) begin
          $error("result transaction with nothing expected");
          errs++;
        end else begin
          exp_r = expected_rsps.pop_front();
          if (out_data_i.result_word !== exp_r.result_word) begin
            $error("result_word expected %h actual %h", exp_r.result_word,
                   out_data_i.result_word);
            errs++;
          end
          if (out_data_i.table_full !== exp_r.table_full) begin
            $error("table_full expected %b actual %b", exp_r.table_full,
                   out_data_i.table_full);
            errs++;
          end
          if (out_data_i.live_count !== exp_r.live_count) begin
            $error("live_count expected %0d actual %0d", exp_r.live_count,
                   out_data_i.live_count);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
      if (in_valid_i && !in_stall_i) predict(in_data_i);
    end
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives get, set, next-key and clear requests into the hash table with
// random gaps and stalls; a checker beside the block judges every result.
// ----------------------------------------------------------------------------
module testbench;
  import cshash_pkg::*;

  localparam int unsigned Cap = 256;

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_stall;
  cs_req_t in_data;
  logic    out_valid;
  logic    out_stall;
  cs_rsp_t out_data;
  int      fail_count;
  int      pending;
  int      sent;
  int      n_sets, n_full_tries;

  logic [63:0] key_pool [16];

  chained_scatter_hash_table #(.CAPACITY(Cap)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  hash_table_checker #(.CAPACITY(Cap)) u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // keys that share a home slot, plus random keys, so chains and moves occur
  function automatic logic [63:0] pick_key();
    int r;
    logic [63:0] k;
    r = $urandom_range(0, 99);
    k = {$urandom, $urandom};
    if (r < 50) return key_pool[$urandom_range(0, 15)];
    if (r < 75) return {k[63:13], 8'($urandom_range(0, 3)), 5'($urandom)};
    if (r < 78) return '0;
    if (r < 80) return '1;
    return k;
  endfunction

  function automatic logic [63:0] pick_val();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 18) return '1;
    return {$urandom, $urandom};
  endfunction

  // one request transaction, held until accepted; valid drops only in a gap
  task automatic send(logic [1:0] t, logic [63:0] k, logic [63:0] v);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_data  <= '{req_type: t, req_key: k, req_value: v};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // receiver stalls at random, with quiet stretches
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) < 30) begin
        out_stall <= 1'b1;
        repeat (gap_len() + 1) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        repeat ($urandom_range(0, 30)) @(posedge clk);
      end
    end
  end

  initial begin
    #100ms;
    $display("FAIL chained_scatter_hash_table");
    $finish;
  end

  initial begin
    int r;
    logic [63:0] k;
    in_valid <= 1'b0;
    in_data  <= '0;
    rst_n    <= 1'b0;
    sent = 0;
    n_sets = 0;
    n_full_tries = 0;
    for (int i = 0; i < 16; i++)
      key_pool[i] = {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_E01F | (64'(i % 4) << 5);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every request type and the special cases
    send(REQ_GET, '0, '0);
    send(REQ_SET, '0, 64'h55);
    send(REQ_SET, 64'h20, '0);
    send(REQ_SET, 64'h20, '1);
    send(REQ_SET, 64'h2020, 64'h1);
    send(REQ_SET, 64'h4020, 64'h2);
    send(REQ_SET, '1, 64'hAAAA_AAAA_AAAA_AAAA);
    send(REQ_SET, 64'h40, 64'h3);
    send(REQ_SET, 64'h2001, 64'h4);
    send(REQ_GET, 64'h2020, '0);
    send(REQ_GET, '1, '0);
    send(REQ_SET, 64'h2020, '0);
    send(REQ_GET, 64'h2020, '0);
    send(REQ_NEXT, '0, '0);
    send(REQ_NEXT, 64'h2020, '0);
    send(REQ_NEXT, 64'h1234, '0);
    send(REQ_SET, 64'h2020, 64'h9);
    send(REQ_NEXT, '1, '1);
    send(REQ_CLEAR, '1, '1);
    send(REQ_GET, 64'h20, '0);

    // random phases: mostly sets with chained keys, some fill to full
    while (sent < 1450) begin
      if ($urandom_range(0, 9) == 0 && sent < 1100) begin
        // fill burst that runs the table out of free slots
        for (int j = 0; j < 300; j++) begin
          k = {$urandom, $urandom};
          send(REQ_SET, k, {$urandom, $urandom} | 64'h1);
          n_full_tries++;
        end
        send(REQ_SET, pick_key(), 64'h7);
        send(REQ_NEXT, '0, '0);
        send(REQ_CLEAR, '0, '0);
      end
      for (int j = 0; j < 40 && sent < 1450; j++) begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          send(REQ_SET, pick_key(), pick_val());
          n_sets++;
        end else if (r < 75) send(REQ_GET, pick_key(), {$urandom, $urandom});
        else if (r < 97) send(REQ_NEXT, pick_key(), {$urandom, $urandom});
        else send(REQ_CLEAR, {$urandom, $urandom}, {$urandom, $urandom});
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("covered %0d requests: %0d random sets, %0d fill-burst sets", sent, n_sets,
             n_full_tries);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS chained_scatter_hash_table");
    end else begin
      $display("FAIL chained_scatter_hash_table");
    end
    $finish;
  end

endmodule
